[hdl/dual_contact_key_velocity_top_defines.svh]
// Assertion macros shared by the key velocity block.
`ifndef DUAL_CONTACT_KEY_VELOCITY_TOP_DEFINES_SVH
`define DUAL_CONTACT_KEY_VELOCITY_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define DCKV_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dckv check failed");
// Next-cycle implication checked outside reset.
`define DCKV_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dckv check failed");
`endif

[hdl/dckv_pkg.sv]
// ----------------------------------------------------------------------------
// dckv_pkg
// Types and constants of the dual contact key velocity block.
// ----------------------------------------------------------------------------
package dckv_pkg;
  localparam int KEY_GROUPS_DEF = 11;
  localparam logic [6:0] NOTE_BASE = 7'd21;

  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_CLEAR_GAP = 3'd1;
  localparam logic [2:0] REG_FAST_LIM  = 3'd2;
  localparam logic [2:0] REG_FAST_SUB  = 3'd3;
  localparam logic [2:0] REG_FLOOR     = 3'd4;
  localparam logic [2:0] REG_CEILING   = 3'd5;
  localparam logic [2:0] REG_SCALE     = 3'd6;
  localparam logic [2:0] REG_OFFSET    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DEB,
    ST_PAIR,
    ST_CMP,
    ST_VSEL,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage

[hdl/dual_contact_key_velocity_top.sv]
// ----------------------------------------------------------------------------
// dual_contact_key_velocity_top
// Two-contact velocity keyboard event detector with a bit-serial divider.
// ----------------------------------------------------------------------------
// An item (key, contact, level, timestamp) is taken when start is high and
// busy is low. Each contact keeps its last level (flip-flops) and the time of
// its last accepted change (a 176-entry memory with one valid bit per entry;
// an entry not valid reads as zero). Time differences are formed serially,
// one bit per cycle, so every compare and subtract is one bit wide. A
// note-on runs a restoring divider, one quotient bit per cycle. An
// out-of-range key is dropped at once and busy stays low. out_valid is
// high for one cycle with is_note_on, note and velocity, in the first
// cycle after busy falls, and the next item may be taken at the end of
// that cycle. Reset restores the register defaults, marks every contact
// open and every stored time as zero; no clearing pass is needed. The
// receiver cannot stall; results are shown for one cycle.
// ----------------------------------------------------------------------------
`include "dual_contact_key_velocity_top_defines.svh"
module dual_contact_key_velocity_top
  import dckv_pkg::*;
#(
  parameter int KEY_GROUPS = KEY_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  in_key_index,
  input  logic        in_contact,
  input  logic        in_level,
  input  logic [31:0] in_timestamp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  output logic        out_is_note_on,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity
);
  localparam int NC = KEY_GROUPS * 16;
  localparam int AW = $clog2(NC);

  logic [19:0] deb_r, gap_r, flim_r, fsub_r, flr_r, ceil_r;
  logic [23:0] scale_r;
  logic [6:0]  offs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= 20'd10000; gap_r <= 20'd3000; flim_r <= 20'd4000;
      fsub_r <= 20'd10000; flr_r <= 20'd5000; ceil_r <= 20'd125000;
      scale_r <= 24'd600000; offs_r <= 7'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  deb_r   <= cfg_data[19:0];
        REG_CLEAR_GAP: gap_r   <= cfg_data[19:0];
        REG_FAST_LIM:  flim_r  <= cfg_data[19:0];
        REG_FAST_SUB:  fsub_r  <= cfg_data[19:0];
        REG_FLOOR:     flr_r   <= cfg_data[19:0];
        REG_CEILING:   ceil_r  <= cfg_data[19:0];
        REG_SCALE:     scale_r <= cfg_data;
        REG_OFFSET:    offs_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Contact state.
  logic [NC-1:0] lvl_r, vld_r;
  logic [31:0]   mem [NC];
  logic [31:0]   rd_r;

  state_t st_r, st_nxt;
  logic [AW-1:0] base_r;
  logic [6:0]    key_r;
  logic          c_r, l_r;
  logic [31:0]   ts_r, own_r, oth_r;
  // Serial operands and running result.
  logic [31:0]   sa_r, sb_r, sd_r, sk_r;
  logic [5:0]    cnt_r;
  logic          cy_r, cy2_r, ready_r;
  logic          rd_sel_r;
  // Per-pass flags.
  logic          dpos_r, dlt_r;
  logic [19:0]   iv_r;
  logic [23:0]   num_r, quo_r;
  logic [20:0]   rem_r;
  logic [4:0]    dcnt_r;
  logic          on_r;
  logic [6:0]    vel_r;

  logic in_range;
  assign in_range = ({1'b0, in_key_index} < 8'(KEY_GROUPS * 8));
  assign busy = (st_r != ST_IDLE);

  logic [AW-1:0] rd_addr;
  assign rd_addr = rd_sel_r ? (base_r | AW'(1)) : base_r;
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end
  logic [AW-1:0] rd_addr_q;
  always_ff @(posedge clk) rd_addr_q <= rd_addr;
  logic [31:0] rd_val;
  assign rd_val = vld_r[rd_addr_q] ? rd_r : 32'd0;

  // One serial step: sum bit of a + ~b + carry (subtract) and of the second
  // operand pair used for comparison against a configured limit.
  logic bd, bk, cyn, cy2n;
  assign {cyn, bd}  = {1'b0, sa_r[0]} + {1'b0, ~sb_r[0]} + {1'b0, cy_r};
  assign {cy2n, bk} = {1'b0, bd} + {1'b0, ~sk_r[0]} + {1'b0, cy2_r};

  // Decisions taken from the stored levels and the finished serial passes.
  logic [AW-1:0] own_idx;
  logic          lvl_same, deb_fail, d_pos, off_hit, on_hit;
  assign own_idx  = base_r | AW'(c_r);
  assign lvl_same = (l_r == lvl_r[own_idx]);
  assign deb_fail = dlt_r || (sd_r == {12'd0, deb_r});
  assign d_pos    = dpos_r && (sd_r != 32'd0);
  assign off_hit  = !c_r && (oth_r == 32'd0) && d_pos;
  assign on_hit   = (oth_r != 32'd0) && d_pos;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start && in_range) st_nxt = ST_RD;
      ST_RD:   if (ready_r) st_nxt = lvl_same ? ST_IDLE : ST_DEB;
      ST_DEB:  if (cnt_r == 6'd32) st_nxt = deb_fail ? ST_IDLE : ST_PAIR;
      ST_PAIR: st_nxt = (!l_r && !c_r) ? ST_IDLE : ST_CMP;
      ST_CMP:  if (cnt_r == 6'd32) st_nxt = ST_VSEL;
      ST_VSEL: begin
        if (l_r) st_nxt = off_hit ? ST_OUT : ST_IDLE;
        else st_nxt = on_hit ? ST_DIV : ST_IDLE;
      end
      ST_DIV:  if (dcnt_r == 5'd0) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // Trial subtraction of the restoring divider.
  logic [20:0] trial;
  assign trial = {rem_r[19:0], num_r[23]} - {1'b0, iv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '1; vld_r <= '0; out_valid <= 1'b0;
      ready_r <= 1'b0; rd_sel_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (start && in_range) begin
            key_r <= in_key_index; c_r <= in_contact; l_r <= in_level;
            ts_r <= in_timestamp;
            base_r <= AW'({in_key_index, 1'b0});
            rd_sel_r <= in_contact; ready_r <= 1'b0; cnt_r <= '0;
          end
        end
        ST_RD: begin
          // Reads the own entry, then the partner entry.
          cnt_r <= cnt_r + 6'd1;
          rd_sel_r <= ~c_r;
          if (cnt_r == 6'd1) own_r <= rd_val;
          if (cnt_r == 6'd2) begin
            oth_r <= rd_val; ready_r <= 1'b1;
          end
          if (ready_r && !lvl_same) begin
            sa_r <= ts_r; sb_r <= own_r; sk_r <= {12'd0, deb_r};
            cy_r <= 1'b1; cy2_r <= 1'b1; sd_r <= '0; cnt_r <= '0;
          end
        end
        ST_DEB, ST_CMP: begin
          if (cnt_r != 6'd32) begin
            sa_r <= sa_r >> 1; sb_r <= sb_r >> 1; sk_r <= sk_r >> 1;
            cy_r <= cyn; cy2_r <= cy2n; sd_r <= {bd, sd_r[31:1]};
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd31) begin
              // d is signed and k is a nonnegative 20-bit value, so d < k
              // when d is negative or when d - k borrows.
              dlt_r <= bd ? 1'b1 : ~cy2n;
              dpos_r <= ~bd;
            end
          end
        end
        ST_PAIR: begin
          lvl_r[own_idx] <= l_r;
          mem[own_idx] <= ts_r;
          vld_r[own_idx] <= 1'b1;
          // Difference own - other, compared with clear_gap or fast_limit.
          sa_r <= ts_r; sb_r <= oth_r;
          sk_r <= {12'd0, (!l_r && c_r) ? flim_r : gap_r};
          cy_r <= 1'b1; cy2_r <= 1'b1; sd_r <= '0; cnt_r <= '0;
        end
        ST_VSEL: begin
          if (l_r) begin
            if (!dlt_r) begin
              mem[own_idx] <= 32'd0;
            end
            if (off_hit) begin
              on_r <= 1'b0; vel_r <= '0;
            end
          end else if (on_hit) begin
            // Clamp chain: d already > 0 here.
            logic [19:0] v;
            v = dlt_r ? fsub_r : (|sd_r[31:20] ? ceil_r : sd_r[19:0]);
            if (!dlt_r && |sd_r[31:20]) v = sd_r[19:0] | 20'hFFFFF;
            if (v < flr_r) v = flr_r;
            if (v > ceil_r) v = ceil_r;
            iv_r <= v; num_r <= scale_r; rem_r <= '0; quo_r <= '0;
            dcnt_r <= 5'd24; on_r <= 1'b1;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (dcnt_r != 5'd0) begin
            num_r <= num_r << 1;
            if (!trial[20]) begin
              rem_r <= trial; quo_r <= {quo_r[22:0], 1'b1};
            end else begin
              rem_r <= {rem_r[19:0], num_r[23]}; quo_r <= {quo_r[22:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 5'd1;
          end else begin
            if (iv_r == 20'd0) vel_r <= 7'd127;
            else if (|quo_r[23:7] || ({1'b0, quo_r[6:0]} + {1'b0, offs_r}) > 8'd127)
              vel_r <= 7'd127;
            else vel_r <= quo_r[6:0] + offs_r;
          end
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_is_note_on <= on_r;
          out_note <= key_r + NOTE_BASE;
          out_velocity <= vel_r;
        end
        default: ;
      endcase
    end
  end

  `DCKV_ASSERT_IMP(a_busy_out, out_valid, $past(busy))
  `DCKV_ASSERT_NXT(a_out_one, out_valid, !out_valid)
  `DCKV_ASSERT_IMP(a_off_zero, out_valid && !out_is_note_on, out_velocity == 7'd0)
endmodule

[tb/dual_contact_key_velocity_top_test.sv]
// ----------------------------------------------------------------------------
// dual_contact_key_velocity_top_test
// Drives contact samples into the key velocity block and compares every
// note event with a local prediction of the key state and velocity.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module dual_contact_key_velocity_top_test
  import dckv_pkg::*;
();

  localparam int NUM_KEYS = KEY_GROUPS_DEF * 8;

  typedef struct packed {
    logic       is_note_on;
    logic [6:0] note;
    logic [6:0] velocity;
  } note_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [6:0]  in_key_index = '0;
  logic        in_contact = 1'b0;
  logic        in_level = 1'b0;
  logic [31:0] in_timestamp = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        out_valid;
  logic        out_is_note_on;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;

  dual_contact_key_velocity_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted configuration and key state.
  logic [19:0] debounce_us, clear_gap_us, fast_lim_us, fast_sub_us;
  logic [19:0] floor_us, ceiling_us;
  logic [23:0] vel_scale;
  logic [6:0]  vel_offset;
  logic        level_mem [2*NUM_KEYS];
  logic [31:0] time_mem [2*NUM_KEYS];

  note_event_t pending_events[$];
  int          error_count = 0;
  logic [31:0] now_us = 32'd100000;

  function automatic logic [6:0] velocity_for(logic signed [31:0] d);
    longint iv;
    longint q;
    iv = d;
    if (iv < fast_lim_us) iv = fast_sub_us;
    if (iv < floor_us) iv = floor_us;
    if (iv > ceiling_us) iv = ceiling_us;
    if (iv <= 0) return 7'd127;
    q = vel_scale / iv + vel_offset;
    return (q > 127) ? 7'd127 : q[6:0];
  endfunction

  task automatic predict_item(logic [6:0] key, logic c, logic lvl, logic [31:0] ts);
    int i0;
    int i1;
    logic signed [31:0] d;
    note_event_t ev;
    if (key >= NUM_KEYS) return;
    i0 = key * 2;
    i1 = i0 + 1;
    if (lvl == level_mem[i0 + c]) return;
    d = ts - time_mem[i0 + c];
    if (!(longint'(d) > longint'(debounce_us))) return;
    time_mem[i0 + c] = ts;
    ev.note = key + NOTE_BASE;
    if (!c && lvl) begin
      d = time_mem[i0] - time_mem[i1];
      if (longint'(d) >= longint'(clear_gap_us)) time_mem[i0] = '0;
      if (time_mem[i1] == 0 && d > 0) begin
        ev.is_note_on = 1'b0;
        ev.velocity = '0;
        pending_events.push_back(ev);
      end
    end else if (c && lvl) begin
      d = time_mem[i1] - time_mem[i0];
      if (longint'(d) >= longint'(clear_gap_us)) time_mem[i1] = '0;
    end else if (c && !lvl) begin
      d = time_mem[i1] - time_mem[i0];
      if (time_mem[i0] != 0 && d > 0) begin
        ev.is_note_on = 1'b1;
        ev.velocity = velocity_for(d);
        pending_events.push_back(ev);
      end
    end
    level_mem[i0 + c] = lvl;
  endtask

  // Sender bursts: a burst of items back to back, then in most cases a random gap.
  int burst_left = 0;

  task automatic send_item(logic [6:0] key, logic c, logic lvl, logic [31:0] ts);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_key_index <= key;
    in_contact <= c;
    in_level <= lvl;
    in_timestamp <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(key, c, lvl, ts);
  endtask

  always @(posedge clk) begin
    note_event_t ev;
    if (rst_n && out_valid) begin
      if (pending_events.size() == 0) begin
        $error("unexpected note event note=%0d", out_note);
        error_count++;
      end else begin
        ev = pending_events.pop_front();
        if (out_is_note_on !== ev.is_note_on) begin
          $error("is_note_on expected %0d actual %0d", ev.is_note_on, out_is_note_on);
          error_count++;
        end
        if (out_note !== ev.note) begin
          $error("note expected %0d actual %0d", ev.note, out_note);
          error_count++;
        end
        if (out_velocity !== ev.velocity) begin
          $error("velocity expected %0d actual %0d", ev.velocity, out_velocity);
          error_count++;
        end
      end
    end
  end

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:  debounce_us = value[19:0];
      REG_CLEAR_GAP: clear_gap_us = value[19:0];
      REG_FAST_LIM:  fast_lim_us = value[19:0];
      REG_FAST_SUB:  fast_sub_us = value[19:0];
      REG_FLOOR:     floor_us = value[19:0];
      REG_CEILING:   ceiling_us = value[19:0];
      REG_SCALE:     vel_scale = value;
      default:       vel_offset = value[6:0];
    endcase
  endtask

  task automatic set_config(logic [19:0] deb, logic [19:0] gap, logic [19:0] flim,
                            logic [19:0] fsub, logic [19:0] fl, logic [19:0] ce,
                            logic [23:0] sc, logic [6:0] off);
    wait_idle();
    write_reg(REG_DEBOUNCE, 24'(deb));
    write_reg(REG_CLEAR_GAP, 24'(gap));
    write_reg(REG_FAST_LIM, 24'(flim));
    write_reg(REG_FAST_SUB, 24'(fsub));
    write_reg(REG_FLOOR, 24'(fl));
    write_reg(REG_CEILING, 24'(ce));
    write_reg(REG_SCALE, sc);
    write_reg(REG_OFFSET, 24'(off));
  endtask

  // One keystroke: first contact closes, second closes after the press
  // interval, then both open again.
  task automatic send_keystroke(logic [6:0] key, logic [31:0] press_us, logic [31:0] hold_us);
    send_item(key, 1'b0, 1'b0, now_us);
    now_us += press_us;
    send_item(key, 1'b1, 1'b0, now_us);
    now_us += hold_us;
    send_item(key, 1'b1, 1'b1, now_us);
    now_us += press_us;
    send_item(key, 1'b0, 1'b1, now_us);
    now_us += 20000;
  endtask

  task automatic test_directed();
    send_keystroke(7'd0, 32'd30000, 32'd50000);
    send_keystroke(7'd87, 32'd1000, 32'd50000);
    send_keystroke(7'd40, 32'd200000, 32'd50000);
    send_keystroke(7'd12, 32'd6000, 32'd50000);
    // Out of range keys, a bounce and an unchanged level.
    send_item(7'd88, 1'b0, 1'b0, now_us);
    send_item(7'd127, 1'b1, 1'b0, now_us);
    send_item(7'd5, 1'b0, 1'b1, now_us);
    send_item(7'd5, 1'b0, 1'b0, now_us);
    send_item(7'd5, 1'b0, 1'b1, now_us + 5);
    // Timestamp wrap across the top of the counter.
    now_us = 32'hFFFF_0000;
    send_keystroke(7'd33, 32'd70000, 32'd40000);
    send_item(7'd1, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_item(7'd1, 1'b0, 1'b1, 32'h0000_0000);
  endtask

  task automatic test_config_extremes();
    // Zero divisor, saturating velocity, floor above ceiling.
    set_config(20'd0, 20'd0, 20'd0, 20'd0, 20'd1, 20'd1, 24'hFFFFFF, 7'd127);
    send_keystroke(7'd2, 32'd10, 32'd10);
    set_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd1, 24'd0, 7'd0);
    now_us += 32'h200000;
    send_keystroke(7'd3, 32'h200000, 32'h200000);
    set_config(20'd0, 20'd100, 20'd0, 20'd0, 20'd0, 20'd0, 24'd1000, 7'd3);
    send_keystroke(7'd4, 32'd0, 32'd50);
    send_keystroke(7'd4, 32'd50, 32'd50);
  endtask

  task automatic test_random(int n_items);
    int sent = 0;
    logic [6:0] key;
    while (sent < n_items) begin
      key = ($urandom_range(0, 99) < 95) ? 7'($urandom_range(0, NUM_KEYS - 1))
                                         : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 9) < 7) begin
        send_keystroke(key, $urandom_range(0, 300000), $urandom_range(0, 60000));
        sent += 4;
      end else begin
        now_us += $urandom_range(0, 20000);
        send_item(key, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 15) == 0) ? $urandom() : now_us);
        sent++;
      end
    end
  endtask

  task automatic test_random_configs();
    repeat (4) begin
      set_config(20'($urandom_range(0, 20000)), 20'($urandom_range(0, 100000)),
                 20'($urandom_range(0, 20000)), 20'($urandom_range(0, 1048575)),
                 20'($urandom_range(0, 20000)), 20'($urandom_range(1, 1048575)),
                 24'($urandom_range(0, 16777215)), 7'($urandom_range(0, 127)));
      test_random(300);
    end
  endtask

  initial begin
    debounce_us = 20'd10000;
    clear_gap_us = 20'd3000;
    fast_lim_us = 20'd4000;
    fast_sub_us = 20'd10000;
    floor_us = 20'd5000;
    ceiling_us = 20'd125000;
    vel_scale = 24'd600000;
    vel_offset = 7'd5;
    for (int i = 0; i < 2 * NUM_KEYS; i++) begin
      level_mem[i] = 1'b1;
      time_mem[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_config_extremes();
    test_random_configs();
    wait_idle();
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("PASS dual_contact_key_velocity_top");
    end else begin
      $display("FAIL dual_contact_key_velocity_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL dual_contact_key_velocity_top");
    $finish;
  end
endmodule

[dual_contact_key_velocity_top.f]
+incdir+hdl
hdl/dckv_pkg.sv
hdl/dual_contact_key_velocity_top.sv
tb/dual_contact_key_velocity_top_test.sv
